// ===== hdl/ssel_pkg.sv =====
// Shared types, constants and table helpers of the setpoint switch selector.
package ssel_pkg;

  // Design defaults for the top-level parameters.
  localparam int SETPOINT_COUNT_DEF  = 5;
  localparam int AUTO_LOW_INDEX_DEF  = 1;
  localparam int AUTO_HIGH_INDEX_DEF = 2;
  localparam int AUTO_DECO_INDEX_DEF = 3;

  // Width of a table index or pick; indexes run up to fifteen.
  localparam int PICK_W        = 4;
  localparam int TABLE_ENTRIES = 5;
  localparam int TABLE_W       = 8 * TABLE_ENTRIES;

  // Depth constants; the _CM ones are in centimetres, NO_LOW_DEPTH_M in metres.
  localparam logic [14:0] DECO_START_RANGE_CM = 15'd300;
  localparam logic [15:0] LOW_MINIMUM_CM      = 16'd100;
  localparam logic [14:0] CM_PER_M            = 15'd100;
  localparam logic [7:0]  NO_LOW_DEPTH_M      = 8'd255;

  // Configuration register map: register index is paddr[5:3].
  localparam int          CFG_ADDR_W   = 6;
  localparam int          CFG_DATA_W   = 64;
  localparam logic [2:0]  REG_AUTO     = 3'd0;
  localparam logic [2:0]  REG_DELAY    = 3'd1;
  localparam logic [2:0]  REG_CCR      = 3'd2;
  localparam logic [2:0]  REG_DECO_EN  = 3'd3;
  localparam logic [2:0]  REG_DEPTHS   = 3'd4;
  localparam logic [2:0]  REG_VALUES   = 3'd5;

  typedef struct packed {
    logic               auto_setpoint;
    logic               delay_low_setpoint;
    logic               ccr_selected;
    logic               deco_setpoint_enabled;
    logic [TABLE_W-1:0] switch_depths;
    logic [TABLE_W-1:0] setpoint_values;
  } cfg_t;

  typedef struct packed {
    logic        in_dive;
    logic [15:0] depth_cm;
    logic [15:0] last_change_depth_cm;
    logic [7:0]  next_stop_m;
    logic [7:0]  active_setpoint_cbar;
  } in_item_t;

  typedef struct packed {
    logic [2:0] setpoint_index;
    logic       switch_warning;
    logic       deco_latched;
    logic       low_deferred;
  } out_item_t;

  // Byte of entry idx (1 to five) of a packed table; other indexes read zero.
  function automatic logic [7:0] table_byte(input logic [TABLE_W-1:0] packed_tbl,
                                            input logic [PICK_W-1:0]  idx);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      4'd1:    b = packed_tbl[7:0];
      4'd2:    b = packed_tbl[15:8];
      4'd3:    b = packed_tbl[23:16];
      4'd4:    b = packed_tbl[31:24];
      4'd5:    b = packed_tbl[39:32];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/ssel_chan_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface ssel_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ssel_seq.sv =====
// Sequencer and shared depth compare unit that work out one setpoint decision.
module ssel_seq #(
  parameter int SETPOINT_COUNT  = ssel_pkg::SETPOINT_COUNT_DEF,
  parameter int AUTO_LOW_INDEX  = ssel_pkg::AUTO_LOW_INDEX_DEF,
  parameter int AUTO_HIGH_INDEX = ssel_pkg::AUTO_HIGH_INDEX_DEF,
  parameter int AUTO_DECO_INDEX = ssel_pkg::AUTO_DECO_INDEX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssel_pkg::cfg_t     cfg,
  ssel_chan_if.sink          in_chan,
  ssel_chan_if.source        out_chan
);

  localparam int CNT_W = $clog2(SETPOINT_COUNT + 1);
  localparam int PW    = ssel_pkg::PICK_W;

  localparam logic [PW-1:0]    LOW_IDX  = PW'(AUTO_LOW_INDEX);
  localparam logic [PW-1:0]    HIGH_IDX = PW'(AUTO_HIGH_INDEX);
  localparam logic [PW-1:0]    DECO_IDX = PW'(AUTO_DECO_INDEX);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SETPOINT_COUNT);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOHI   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECO   = 6'b001000,
    ST_RULE   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [15:0]          cur_r, last_r;
  logic [7:0]           ns_r, act_r;
  logic                 desc_r, force_one_r;
  logic [PW-1:0]        pick_r, pick_nxt;
  logic [7:0]           best_r, best_nxt;
  logic [7:0]           lo_best_r, lo_best_nxt, hi_best_r, hi_best_nxt;
  logic [CNT_W-1:0]     lo_id_r, lo_id_nxt, hi_id_r, hi_id_nxt;
  logic [2:0]           chosen_r, chosen_nxt;
  logic                 deco_r, deco_nxt, def_r, def_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ssel_pkg::out_item_t  out_r, out_nxt;

  // Shared unit: fetch one switch depth and scale it to centimetres.
  logic [PW-1:0] ent_idx;
  logic [7:0]    ent_m;
  logic [15:0]   ent_cm;
  logic [15:0]   deco_thr_cm;
  logic          accept, slot_free;

  ssel_pkg::in_item_t in_item;

  assign in_item   = in_chan.payload;
  assign accept    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready    = rst_n && (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  always_comb begin
    if (state_r == ST_RULE) begin
      ent_idx = desc_r ? HIGH_IDX : LOW_IDX;
    end else begin
      ent_idx = PW'(idx_r);
    end
  end

  assign ent_m       = ssel_pkg::table_byte(cfg.switch_depths, ent_idx);
  assign ent_cm      = 16'(15'(ent_m) * ssel_pkg::CM_PER_M);
  assign deco_thr_cm = 16'(15'(ns_r) * ssel_pkg::CM_PER_M + ssel_pkg::DECO_START_RANGE_CM);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    lo_best_nxt   = lo_best_r;
    hi_best_nxt   = hi_best_r;
    lo_id_nxt     = lo_id_r;
    hi_id_nxt     = hi_id_r;
    chosen_nxt    = chosen_r;
    deco_nxt      = deco_r;
    def_nxt       = def_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt     = CNT_W'(1);
          pick_nxt    = '0;
          lo_best_nxt = ssel_pkg::NO_LOW_DEPTH_M;
          hi_best_nxt = 8'd0;
          lo_id_nxt   = '0;
          hi_id_nxt   = '0;
          best_nxt    = (in_item.depth_cm > in_item.last_change_depth_cm) ? 8'd0 : 8'd255;
          if (!in_item.in_dive || !cfg.ccr_selected ||
              in_item.depth_cm == in_item.last_change_depth_cm) begin
            state_nxt = ST_FINISH;
          end else if (cfg.auto_setpoint) begin
            state_nxt = ST_DECO;
          end else begin
            state_nxt = ST_LOHI;
          end
        end
      end

      ST_LOHI: begin
        if (ent_m != 8'd0 && ent_m < lo_best_r) begin
          lo_id_nxt   = idx_r;
          lo_best_nxt = ent_m;
        end
        if (ent_m != 8'd0 && ent_m >= hi_best_r) begin
          hi_id_nxt   = idx_r;
          hi_best_nxt = ent_m;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = CNT_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_SCAN: begin
        if (!(ent_m == 8'd0 || (desc_r && idx_r == lo_id_r) ||
              (!desc_r && idx_r == hi_id_r))) begin
          if ((desc_r && last_r < ent_cm && ent_cm < cur_r && ent_m > best_r) ||
              (!desc_r && last_r > ent_cm && ent_cm > cur_r && ent_m <= best_r)) begin
            pick_nxt = PW'(idx_r);
            best_nxt = ent_m;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_DECO: begin
        if (cfg.deco_setpoint_enabled && ns_r != 8'd0 && cur_r < deco_thr_cm && !deco_r) begin
          pick_nxt = DECO_IDX;
          deco_nxt = 1'b1;
        end
        state_nxt = ST_RULE;
      end

      ST_RULE: begin
        if (desc_r) begin
          if (last_r < ent_cm && ent_cm < cur_r && !deco_r) begin
            pick_nxt = HIGH_IDX;
          end
        end else if (last_r > ssel_pkg::LOW_MINIMUM_CM && cur_r < ssel_pkg::LOW_MINIMUM_CM) begin
          pick_nxt = LOW_IDX;
          def_nxt  = 1'b0;
        end else if (last_r > ent_cm && ent_cm > cur_r) begin
          if (ns_r != 8'd0 && cfg.delay_low_setpoint) begin
            def_nxt = 1'b1;
          end else begin
            pick_nxt = LOW_IDX;
          end
        end
        if (ns_r == 8'd0) begin
          deco_nxt = 1'b0;
          if (def_nxt) begin
            pick_nxt = LOW_IDX;
            def_nxt  = 1'b0;
          end
        end
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        if (slot_free) begin
          out_nxt.switch_warning = 1'b0;
          if (force_one_r) begin
            chosen_nxt = 3'd1;
          end else if (pick_r != '0) begin
            chosen_nxt = pick_r[2:0];
            out_nxt.switch_warning =
              (ssel_pkg::table_byte(cfg.setpoint_values, pick_r) != act_r);
          end
          out_nxt.setpoint_index = chosen_nxt;
          out_nxt.deco_latched   = deco_r;
          out_nxt.low_deferred   = def_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chosen_r    <= 3'd1;
      deco_r      <= 1'b0;
      def_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chosen_r    <= chosen_nxt;
      deco_r      <= deco_nxt;
      def_r       <= def_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pick_r    <= pick_nxt;
    best_r    <= best_nxt;
    lo_best_r <= lo_best_nxt;
    hi_best_r <= hi_best_nxt;
    lo_id_r   <= lo_id_nxt;
    hi_id_r   <= hi_id_nxt;
    out_r     <= out_nxt;
    if (accept) begin
      cur_r       <= in_item.depth_cm;
      last_r      <= in_item.last_change_depth_cm;
      ns_r        <= in_item.next_stop_m;
      act_r       <= in_item.active_setpoint_cbar;
      desc_r      <= in_item.depth_cm > in_item.last_change_depth_cm;
      force_one_r <= !in_item.in_dive;
    end
  end

endmodule

// ===== hdl/setpoint_switch_selector.sv =====
// Top level of the setpoint switch selector: register port and decision sequencer.
//
// Each depth item yields one result item: the suggested setpoint table index,
// a warning when that entry's setpoint differs from the one in use, and the
// latched deco and deferred-low flags. The block takes one item at a time and
// is not ready while it works on it. An item outside a dive, outside closed
// circuit mode or with no depth change goes straight from acceptance to the
// result step; in automatic mode an item passes through acceptance, the deco
// rule, the high/low rules, then the result; in manual mode one shared depth
// fetch and compare unit first walks the table for the low and high entries
// and then walks it again for the crossed switch depth before the result.
// The result waits in an output register, so the next item can be accepted
// while it is still to be taken; the final step of that next item then waits
// until the earlier result is taken. Configuration registers sit at byte
// address 8*i (automatic mode, delayed low, closed circuit, deco entry enable,
// packed switch depths, packed setpoint values) and should only be written
// while the block is idle.
module setpoint_switch_selector #(
  parameter int SETPOINT_COUNT  = ssel_pkg::SETPOINT_COUNT_DEF,
  parameter int AUTO_LOW_INDEX  = ssel_pkg::AUTO_LOW_INDEX_DEF,
  parameter int AUTO_HIGH_INDEX = ssel_pkg::AUTO_HIGH_INDEX_DEF,
  parameter int AUTO_DECO_INDEX = ssel_pkg::AUTO_DECO_INDEX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssel_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ssel_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ssel_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  ssel_chan_if.sink                       in_chan,
  ssel_chan_if.source                     out_chan
);

  logic                         auto_r, delay_r, ccr_r, deco_en_r;
  logic [ssel_pkg::TABLE_W-1:0] depths_r, values_r;
  logic [2:0]                   reg_sel;
  logic                         wr_en;
  ssel_pkg::cfg_t               cfg;

  // The register index is the byte address divided by eight.
  assign reg_sel = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r    <= 1'b0;
      delay_r   <= 1'b0;
      ccr_r     <= 1'b0;
      deco_en_r <= 1'b0;
      depths_r  <= '0;
      values_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        ssel_pkg::REG_AUTO:    auto_r    <= pwdata[0];
        ssel_pkg::REG_DELAY:   delay_r   <= pwdata[0];
        ssel_pkg::REG_CCR:     ccr_r     <= pwdata[0];
        ssel_pkg::REG_DECO_EN: deco_en_r <= pwdata[0];
        ssel_pkg::REG_DEPTHS:  depths_r  <= pwdata[ssel_pkg::TABLE_W-1:0];
        ssel_pkg::REG_VALUES:  values_r  <= pwdata[ssel_pkg::TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, zero-extended; unmapped addresses read zero.
  always_comb begin
    unique case (reg_sel)
      ssel_pkg::REG_AUTO:    prdata = ssel_pkg::CFG_DATA_W'(auto_r);
      ssel_pkg::REG_DELAY:   prdata = ssel_pkg::CFG_DATA_W'(delay_r);
      ssel_pkg::REG_CCR:     prdata = ssel_pkg::CFG_DATA_W'(ccr_r);
      ssel_pkg::REG_DECO_EN: prdata = ssel_pkg::CFG_DATA_W'(deco_en_r);
      ssel_pkg::REG_DEPTHS:  prdata = ssel_pkg::CFG_DATA_W'(depths_r);
      ssel_pkg::REG_VALUES:  prdata = ssel_pkg::CFG_DATA_W'(values_r);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    cfg.auto_setpoint         = auto_r;
    cfg.delay_low_setpoint    = delay_r;
    cfg.ccr_selected          = ccr_r;
    cfg.deco_setpoint_enabled = deco_en_r;
    cfg.switch_depths         = depths_r;
    cfg.setpoint_values       = values_r;
  end

  // The sequencer holds the chosen index and both flags across items.
  ssel_seq #(
    .SETPOINT_COUNT  (SETPOINT_COUNT),
    .AUTO_LOW_INDEX  (AUTO_LOW_INDEX),
    .AUTO_HIGH_INDEX (AUTO_HIGH_INDEX),
    .AUTO_DECO_INDEX (AUTO_DECO_INDEX)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
